@@ src/bstk_pkg.sv @@
`timescale 1ns / 1ps

package bstk_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 11;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_PEEK = 2'd2,
        ACT_SUM  = 2'd3
    } t_action;

    typedef struct packed {
        t_action                    action;
        logic signed [DATA_W-1:0]   push_value;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0]   value;
        logic                       ok;
        logic                       empty_res;
        logic signed [DATA_W-1:0]   average;
        logic signed [DATA_W-1:0]   maximum;
        logic signed [DATA_W-1:0]   minimum;
        logic        [COUNT_W-1:0]  nonzero_count;
        logic        [COUNT_W-1:0]  zero_count;
        logic        [COUNT_W-1:0]  positive_count;
        logic        [COUNT_W-1:0]  negative_count;
    } t_out;

endpackage

@@ src/bstk_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module bstk_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/bounded_stack_with_statistics_top.sv @@
`timescale 1ns / 1ps
// A push gives its result in the cycle after acceptance; a pop or peek reads the RAM at
// acceptance and gives its result from S_READ. A summarize walks the RAM read port one word
// per cycle, then runs the one-bit-per-cycle divider over a SUM_W-bit quotient (SUM_W = 32 +
// occupancy width, 43 at DEPTH 1024). One transaction is in flight at a time; busy is high
// until the result cycle. Synchronous active-low reset empties the stack; RAM contents are kept.
// Results are shown for exactly one cycle with o_done; the receiver cannot stall.

module bounded_stack_with_statistics_top #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  bstk_pkg::t_in   i_item,
    output logic            o_busy,
    output logic            o_done,
    output bstk_pkg::t_out  o_result
);

    // Occupancy needs to hold DEPTH itself; RAM addresses need only DEPTH-1.
    localparam int unsigned OCC_W  = $clog2(DEPTH + 1);
    localparam int unsigned AW     = $clog2(DEPTH);
    // The exact sum of up to DEPTH signed 32-bit words fits in 32 + OCC_W bits.
    localparam int unsigned SUM_W  = bstk_pkg::DATA_W + OCC_W;
    localparam int unsigned STEP_W = $clog2(SUM_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WALK,
        S_DIV,
        S_FIN
    } t_state;

    t_state                          r_state;
    logic [OCC_W-1:0]                r_occ;
    logic                            r_done;
    bstk_pkg::t_out                  r_out;

    // Summary walk and statistics.
    logic [OCC_W-1:0]                r_addr;
    logic                            r_vld;
    logic signed [SUM_W-1:0]         r_sum;
    logic signed [bstk_pkg::DATA_W-1:0] r_max;
    logic signed [bstk_pkg::DATA_W-1:0] r_min;
    logic [OCC_W-1:0]                r_cnt_nz;
    logic [OCC_W-1:0]                r_cnt_z;
    logic [OCC_W-1:0]                r_cnt_pos;
    logic [OCC_W-1:0]                r_cnt_neg;

    // Restoring divider: quotient shifts in where the dividend shifts out.
    logic [SUM_W-1:0]                r_quo;
    logic [OCC_W:0]                  r_rem;
    logic                            r_neg;
    logic [STEP_W-1:0]               r_step;

    // RAM port signals.
    logic                            w_we;
    logic                            w_re;
    logic [AW-1:0]                   w_raddr;
    logic [bstk_pkg::DATA_W-1:0]     w_rdata;

    logic                            w_accept;
    logic                            w_full;
    logic                            w_empty;
    logic [OCC_W-1:0]                w_top;
    logic                            w_walk_rd;
    logic signed [bstk_pkg::DATA_W-1:0] w_word;
    logic signed [SUM_W-1:0]         n_sum;
    logic [OCC_W:0]                  n_rem_sh;
    logic                            n_ge;

    assign w_accept  = i_start && (r_state == S_IDLE);
    assign w_full    = (r_occ == OCC_W'(DEPTH));
    assign w_empty   = (r_occ == '0);
    assign w_top     = r_occ - OCC_W'(1);
    assign w_walk_rd = (r_state == S_WALK) && (r_addr != r_occ);
    assign w_word    = signed'(w_rdata);
    assign n_sum     = r_sum + SUM_W'(w_word);
    assign n_rem_sh  = {r_rem[OCC_W-1:0], r_quo[SUM_W-1]};
    assign n_ge      = (n_rem_sh >= {1'b0, r_occ});

    // A push writes at the current top; pop and peek read one below it. The walk reads
    // upward from entry 0, one word per cycle.
    always_comb begin
        w_we    = w_accept && (i_item.action == bstk_pkg::ACT_PUSH) && !w_full;
        w_re    = 1'b0;
        w_raddr = w_top[AW-1:0];
        if (w_accept && !w_empty &&
            (i_item.action inside {bstk_pkg::ACT_POP, bstk_pkg::ACT_PEEK})) begin
            w_re = 1'b1;
        end else if (w_walk_rd) begin
            w_re    = 1'b1;
            w_raddr = r_addr[AW-1:0];
        end
    end

    bstk_ram #(
        .WIDTH (bstk_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_occ[AW-1:0]),
        .i_wdata (i_item.push_value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_done  <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_out <= '0;
                        case (i_item.action)
                            bstk_pkg::ACT_PUSH: begin
                                // The write itself happens in the RAM at this edge.
                                r_done <= 1'b1;
                                if (!w_full) begin
                                    r_occ        <= r_occ + OCC_W'(1);
                                    r_out.ok     <= 1'b1;
                                end else begin
                                    r_out.empty_res <= w_empty;
                                end
                            end
                            bstk_pkg::ACT_POP, bstk_pkg::ACT_PEEK: begin
                                if (w_empty) begin
                                    r_done          <= 1'b1;
                                    r_out.empty_res <= 1'b1;
                                end else begin
                                    if (i_item.action == bstk_pkg::ACT_POP) begin
                                        r_occ <= w_top;
                                    end
                                    r_state <= S_READ;
                                end
                            end
                            bstk_pkg::ACT_SUM: begin
                                if (w_empty) begin
                                    r_done          <= 1'b1;
                                    r_out.empty_res <= 1'b1;
                                end else begin
                                    // Extreme start values give the same result as seeding
                                    // with entry 0, since at least one word is present.
                                    r_addr    <= '0;
                                    r_vld     <= 1'b0;
                                    r_sum     <= '0;
                                    r_max     <= {1'b1, {(bstk_pkg::DATA_W-1){1'b0}}};
                                    r_min     <= {1'b0, {(bstk_pkg::DATA_W-1){1'b1}}};
                                    r_cnt_nz  <= '0;
                                    r_cnt_z   <= '0;
                                    r_cnt_pos <= '0;
                                    r_cnt_neg <= '0;
                                    r_state   <= S_WALK;
                                end
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_out.value     <= w_word;
                    r_out.ok        <= 1'b1;
                    r_out.empty_res <= w_empty;
                    r_done          <= 1'b1;
                    r_state         <= S_IDLE;
                end
                S_WALK: begin
                    if (w_walk_rd) begin
                        r_addr <= r_addr + OCC_W'(1);
                    end
                    r_vld <= w_walk_rd;
                    if (r_vld) begin
                        r_sum     <= n_sum;
                        if (w_word > r_max) begin
                            r_max <= w_word;
                        end
                        if (w_word < r_min) begin
                            r_min <= w_word;
                        end
                        r_cnt_nz  <= r_cnt_nz  + OCC_W'(w_word != 0);
                        r_cnt_z   <= r_cnt_z   + OCC_W'(w_word == 0);
                        r_cnt_pos <= r_cnt_pos + OCC_W'(w_word > 0);
                        r_cnt_neg <= r_cnt_neg + OCC_W'(w_word < 0);
                    end
                    if (!w_walk_rd && !r_vld) begin
                        // Divide the magnitude; the sign goes back on at the end.
                        r_neg   <= r_sum[SUM_W-1];
                        r_quo   <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_quo  <= {r_quo[SUM_W-2:0], n_ge};
                    r_rem  <= n_ge ? (n_rem_sh - {1'b0, r_occ}) : n_rem_sh;
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(SUM_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_out.value          <= '0;
                    r_out.ok             <= 1'b0;
                    r_out.empty_res      <= 1'b0;
                    r_out.average        <= r_neg ? bstk_pkg::DATA_W'(-r_quo)
                                                  : bstk_pkg::DATA_W'(r_quo);
                    r_out.maximum        <= r_max;
                    r_out.minimum        <= r_min;
                    r_out.nonzero_count  <= bstk_pkg::COUNT_W'(r_cnt_nz);
                    r_out.zero_count     <= bstk_pkg::COUNT_W'(r_cnt_z);
                    r_out.positive_count <= bstk_pkg::COUNT_W'(r_cnt_pos);
                    r_out.negative_count <= bstk_pkg::COUNT_W'(r_cnt_neg);
                    r_done               <= 1'b1;
                    r_state              <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

    // Occupancy never passes the capacity.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(DEPTH))
        else $error("occupancy above capacity");

    // No transaction can be accepted while busy, so occupancy holds.
    a_occ_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> $stable(r_occ))
        else $error("occupancy changed while busy");

    // A pop on a non-empty stack removes exactly one word.
    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.action == bstk_pkg::ACT_POP && !w_empty)
        |=> (r_occ == $past(r_occ) - OCC_W'(1)))
        else $error("pop did not remove one word");

    // A result's empty flag agrees with the occupancy it leaves behind.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.empty_res == (r_occ == '0)))
        else $error("empty flag disagrees with occupancy");

    // A result only follows an acceptance, a read or the end of a summary.
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_done) |-> ($past(w_accept) || $past(r_state == S_READ)
                           || $past(r_state == S_FIN)))
        else $error("result without a transaction");

endmodule
